// ===== hw/rtl/sprq_pkg.sv =====
// Shared types and constants for the stable priority ready queue.
// Holds the status codes, the action codes and the cell command struct.
// No dependencies.
package sprq_pkg;

  // Widths of the stream fields, fixed by the interface.
  localparam int unsigned IN_ID_W   = 8;
  localparam int unsigned IN_PRIO_W = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned OUT_DATA_W = 24;

  // Action codes carried in the input tuser.
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // Result status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     head_only;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sprq_cell.sv =====
// One slot of the sorted chain: holds an identifier and its priority.
// Depends on sprq_pkg for the cell command struct.
module sprq_cell #(
  parameter int unsigned ID_WIDTH   = 8,
  parameter int unsigned PRIO_WIDTH = 8
) (
  input  logic                  clk,
  input  sprq_pkg::cell_ctl_t   ctl,
  input  logic                  occ,
  input  logic [ID_WIDTH-1:0]   new_id,
  input  logic [PRIO_WIDTH-1:0] new_prio,
  input  logic                  left_ge,
  input  logic [ID_WIDTH-1:0]   left_id,
  input  logic [PRIO_WIDTH-1:0] left_prio,
  input  logic [ID_WIDTH-1:0]   right_id,
  input  logic [PRIO_WIDTH-1:0] right_prio,
  output logic                  ge,
  output logic [ID_WIDTH-1:0]   id,
  output logic [PRIO_WIDTH-1:0] prio
);
  import sprq_pkg::*;

  logic [ID_WIDTH-1:0]   id_r, id_nxt;
  logic [PRIO_WIDTH-1:0] prio_r, prio_nxt;

  // An occupied slot whose priority is at least the new one stays ahead of it.
  assign ge = occ && (prio_r >= new_prio);

  // Insert: stay, take the new word at the boundary, or take the left word.
  // Remove: take the right word; with head_only set, only occupied slots take it.
  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (!ge) begin
          if (left_ge) begin
            id_nxt   = new_id;
            prio_nxt = new_prio;
          end else begin
            id_nxt   = left_id;
            prio_nxt = left_prio;
          end
        end
      end
      CELL_REMOVE: begin
        if (!ctl.head_only || occ) begin
          id_nxt   = right_id;
          prio_nxt = right_prio;
        end
      end
      default: begin
        id_nxt   = id_r;
        prio_nxt = prio_r;
      end
    endcase
  end

  // Slot payload needs no reset; only slots below the count are read.
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign id   = id_r;
  assign prio = prio_r;

endmodule

// ===== hw/rtl/stable_priority_ready_queue.sv =====
// Top level of the stable priority ready queue: a chain of sorted cells,
// the entry count and the output register. Depends on sprq_pkg and sprq_cell.
//
// Usage:
//   The input channel carries one word per request. in_tuser selects the
//   action (enqueue or dequeue); in_tdata carries the identifier and its
//   priority. Every accepted word gives exactly one result word on the
//   output channel: out_tuser holds the status (ok, empty, full) and
//   out_tdata the removed identifier, its priority and the occupancy after
//   the request.
//   Entries are kept highest priority first; equal priorities leave in the
//   order they arrived. An enqueue into a full queue is dropped.
//   The result is registered and shows on out_tvalid in the cycle after
//   acceptance. Throughput is one word per cycle while the receiver keeps
//   up: every cell compares its own priority with the incoming one and
//   shifts toward its neighbor in the same cycle, so no request waits for another.
//   When the receiver stalls, the pending result holds in the output
//   register and in_tready drops; a new word is taken in the same cycle
//   the pending result is taken.
//   Reset (rst_n low, synchronous) empties the queue and clears the
//   output valid. No clearing pass follows reset.
module stable_priority_ready_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ID_WIDTH   = 8,
  parameter int unsigned PRIO_WIDTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Bits from low: entry_id[7:0], priority_req[15:8].
  input  logic [sprq_pkg::IN_ID_W+sprq_pkg::IN_PRIO_W-1:0] in_tdata,
  // Bits from low: action[0].
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Bits from low: head_id[7:0], head_priority[15:8], occupancy[20:16], zero.
  output logic [sprq_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Bits from low: status[1:0].
  output logic [sprq_pkg::STATUS_W-1:0]        out_tuser
);
  import sprq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [IN_ID_W-1:0]    head_id_r, head_id_nxt;
  logic [IN_PRIO_W-1:0]  head_prio_r, head_prio_nxt;

  logic                  in_fire;
  logic                  is_full, is_empty;
  logic [ID_WIDTH-1:0]   new_id;
  logic [PRIO_WIDTH-1:0] new_prio;
  cell_ctl_t             ctl;

  logic [DEPTH-1:0]      cell_ge;
  logic [DEPTH-1:0]      cell_occ;
  logic [ID_WIDTH-1:0]   cell_id   [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];

  // Handshake: a new word enters whenever the output register frees up.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign new_id   = ID_WIDTH'(in_tdata[IN_ID_W-1:0]);
  assign new_prio = PRIO_WIDTH'(in_tdata[IN_ID_W+IN_PRIO_W-1:IN_ID_W]);

  // Decode the command for the chain and the next count and result.
  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.head_only = 1'b0;
    count_nxt     = count_r;
    status_nxt    = status_r;
    head_id_nxt   = head_id_r;
    head_prio_nxt = head_prio_r;
    if (in_fire) begin
      status_nxt    = ST_OK;
      head_id_nxt   = '0;
      head_prio_nxt = '0;
      if (in_tuser == ACT_ENQUEUE) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.op    = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.op        = CELL_REMOVE;
          count_nxt     = count_r - CNT_W'(1);
          head_id_nxt   = IN_ID_W'(cell_id[0]);
          head_prio_nxt = IN_PRIO_W'(cell_prio[0]);
        end
      end
    end
  end

  // The chain of cells; each one sees its left and right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_ge;
    logic [ID_WIDTH-1:0]   left_id, right_id;
    logic [PRIO_WIDTH-1:0] left_prio, right_prio;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_ge   = 1'b1;
      assign left_id   = new_id;
      assign left_prio = new_prio;
    end else begin : g_mid
      assign left_ge   = cell_ge[i-1];
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id   = new_id;
      assign right_prio = new_prio;
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    sprq_cell #(
      .ID_WIDTH   (ID_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (cell_occ[i]),
      .new_id     (new_id),
      .new_prio   (new_prio),
      .left_ge    (left_ge),
      .left_id    (left_id),
      .left_prio  (left_prio),
      .right_id   (right_id),
      .right_prio (right_prio),
      .ge         (cell_ge[i]),
      .id         (cell_id[i]),
      .prio       (cell_prio[i])
    );
  end

  // Count and output valid are control state; the result word is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    status_r    <= status_nxt;
    head_id_r   <= head_id_nxt;
    head_prio_r <= head_prio_nxt;
  end

  // The occupancy reported is the count after the request.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_DATA_W - IN_ID_W - IN_PRIO_W - OCC_W){1'b0}},
                       OCC_W'(count_r), head_prio_r, head_id_r};

`ifndef NO_ASSERTIONS
  // The count never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A full result leaves the queue at full occupancy.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> is_full)
    else $error("full status with free slots");

  // A successful dequeue lowers the count by one.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == ACT_DEQUEUE && !is_empty)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not lower the count");

  // Every accepted word leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  // The first two cells, when occupied, stay in descending priority order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ[1] && !$isunknown(cell_prio[1])) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head cells out of priority order");
`endif

endmodule
